>>> sv/ax25fcs_pkg.sv
// ----------------------------------------------------------------------------
// ax25fcs_pkg
// Shared types and constants for the AX.25 frame and FCS builder.
// ----------------------------------------------------------------------------
package ax25fcs_pkg;

    // HDLC flag and CRC constants
    localparam logic [7:0]  FLAG_BYTE     = 8'h7E;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam int          CNT_W         = 6;
    localparam logic [CNT_W-1:0] CLOSE_LAST     = 6'd2;   // three closing flags
    localparam logic [CNT_W-1:0] MAX_OPEN_FLAGS = 6'd32;
    localparam logic [CNT_W-1:0] MIN_OPEN_FLAGS = 6'd1;
    localparam logic [CNT_W-1:0] OPEN_FLAGS_RST = 6'd4;

    // One accepted body byte with its framing marks
    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
        logic       frame_end;
        logic       is_address;
        logic       address_end;
    } ax25fcs_in_t;

    // One emitted frame byte
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_complete;
    } ax25fcs_out_t;

    // Emission phase of the item held in the work register
    typedef enum logic [2:0] {
        PH_OPEN,
        PH_BODY,
        PH_FCS_LO,
        PH_FCS_HI,
        PH_CLOSE
    } ax25fcs_phase_t;

endpackage

>>> sv/ax25_frame_fcs_builder.sv
// ----------------------------------------------------------------------------
// ax25_frame_fcs_builder
// Wraps AX.25 body bytes with opening flags, the complemented FCS and
// three closing flags.
// ----------------------------------------------------------------------------
// Throughput: an item is held in the work register, and each frame byte it
//   emits is registered in the output register, one frame byte per cycle while
//   out_ready does not hold the output; an item holds the work register until it
//   has emitted all its bytes (one for a plain body byte, up to 38 at a frame start and end).
// Reset: rst_n clears handshake state, sets the CRC to 0xFFFF and the opening
//   flag count to 4.
module ax25_frame_fcs_builder (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [5:0]                cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  ax25fcs_pkg::ax25fcs_in_t  in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output ax25fcs_pkg::ax25fcs_out_t out_data
);

    import ax25fcs_pkg::*;

    logic [CNT_W-1:0] flag_cfg_reg;
    logic             cur_valid_reg;
    logic             cur_valid_next;
    ax25fcs_in_t      cur_item_reg;
    ax25fcs_phase_t   phase_reg;
    ax25fcs_phase_t   phase_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [15:0]      crc_reg;
    logic [15:0]      crc_next;
    logic             out_valid_reg;
    ax25fcs_out_t     out_item_reg;

    logic             out_free;
    logic             emit;
    logic             item_done;
    logic             in_xfer;
    logic [CNT_W-1:0] open_limit;
    logic [7:0]       body_byte;
    logic [15:0]      crc_base;
    logic [15:0]      crc_folded;
    ax25fcs_out_t     res;

    // config register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            flag_cfg_reg <= OPEN_FLAGS_RST;
        else if (cfg_valid)
            flag_cfg_reg <= cfg_data;
    end

    // clamp flag count to 1..32
    always_comb
    begin
        if (flag_cfg_reg == '0)
            open_limit = MIN_OPEN_FLAGS;
        else if (flag_cfg_reg > MAX_OPEN_FLAGS)
            open_limit = MAX_OPEN_FLAGS;
        else
            open_limit = flag_cfg_reg;
    end

    // address shaping of the body byte
    always_comb
    begin
        body_byte = cur_item_reg.is_address ? {cur_item_reg.data_byte[6:0], 1'b0}
                                            : cur_item_reg.data_byte;
        if (cur_item_reg.address_end)
            body_byte[0] = 1'b1;
    end

    // CRC restarts on the first body byte of a frame
    assign crc_base = cur_item_reg.frame_start ? CRC_INIT : crc_reg;

    ax25fcs_crc_fold u_crc (
        .crc_in  (crc_base),
        .data_in (body_byte),
        .crc_out (crc_folded)
    );

    // handshake
    assign out_free = !out_valid_reg || out_ready;
    assign emit     = cur_valid_reg && out_free;
    assign in_ready = !cur_valid_reg || (emit && item_done);
    assign in_xfer  = in_valid && in_ready;

    // sequencer: next phase and the byte emitted this cycle
    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        crc_next   = crc_reg;
        item_done  = 1'b0;
        res        = '{out_byte: FLAG_BYTE, run_last: 1'b0, frame_complete: 1'b0};
        case (phase_reg)
            PH_OPEN:
            begin
                if (cnt_reg == open_limit - 6'd1)
                begin
                    phase_next = PH_BODY;
                    cnt_next   = '0;
                end
                else
                    cnt_next = cnt_reg + 6'd1;
            end
            PH_BODY:
            begin
                res.out_byte = body_byte;
                res.run_last = !cur_item_reg.frame_end;
                crc_next     = crc_folded;
                if (cur_item_reg.frame_end)
                    phase_next = PH_FCS_LO;
                else
                    item_done = 1'b1;
            end
            PH_FCS_LO:
            begin
                res.out_byte = ~crc_reg[7:0];
                phase_next   = PH_FCS_HI;
            end
            PH_FCS_HI:
            begin
                res.out_byte = ~crc_reg[15:8];
                phase_next   = PH_CLOSE;
                cnt_next     = '0;
            end
            PH_CLOSE:
            begin
                if (cnt_reg == CLOSE_LAST)
                begin
                    res.run_last       = 1'b1;
                    res.frame_complete = 1'b1;
                    item_done          = 1'b1;
                end
                else
                    cnt_next = cnt_reg + 6'd1;
            end
            default:
            begin
                item_done = 1'b1;
            end
        endcase

        // load a new item, or hold when the output is blocked
        if (!emit)
        begin
            phase_next = phase_reg;
            cnt_next   = cnt_reg;
            crc_next   = crc_reg;
        end
        if (in_xfer)
        begin
            phase_next = in_data.frame_start ? PH_OPEN : PH_BODY;
            cnt_next   = '0;
        end
        cur_valid_next = in_xfer || (cur_valid_reg && !(emit && item_done));
    end

    // control and CRC state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            phase_reg     <= PH_BODY;
            cnt_reg       <= '0;
            crc_reg       <= CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            crc_reg       <= crc_next;
            if (out_free)
                out_valid_reg <= emit;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            cur_item_reg <= in_data;
        if (emit)
            out_item_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

endmodule

>>> sv/ax25fcs_crc_fold.sv
// ----------------------------------------------------------------------------
// ax25fcs_crc_fold
// Byte-wide update of the reflected CRC-16/X.25 (poly 0x8408).
// ----------------------------------------------------------------------------
module ax25fcs_crc_fold (
    input  logic [15:0] crc_in,
    input  logic [7:0]  data_in,
    output logic [15:0] crc_out
);

    logic [7:0]  d0;
    logic [7:0]  d1;
    logic [15:0] d_ext;

    // table-free form: d = (b ^ crc_lo); d ^= d << 4
    always_comb
    begin
        d0      = data_in ^ crc_in[7:0];
        d1      = d0 ^ {d0[3:0], 4'b0000};
        d_ext   = {8'h00, d1};
        crc_out = {d1, crc_in[15:8]} ^ (d_ext >> 4) ^ (d_ext << 3);
    end

endmodule
